FILE: hdl/sfs_pkg.sv
package sfs_pkg;

   localparam int ANIMATIONS      = 16;
   localparam int FRAMES_PER_ANIM = 32;
   localparam int HISTORY_DEPTH   = 20;

   localparam int ANIM_W   = $clog2(ANIMATIONS);
   localparam int FRAME_W  = $clog2(FRAMES_PER_ANIM);
   localparam int CNT_W    = $clog2(FRAMES_PER_ANIM + 1);
   localparam int HCNT_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int HIDX_W   = $clog2(HISTORY_DEPTH);
   localparam int TAB_AW   = ANIM_W + FRAME_W;
   localparam int TAB_DEPTH = ANIMATIONS * FRAMES_PER_ANIM;

   localparam int TIME_W   = 24;
   localparam int SPEED_W  = 16;
   localparam int TILE_W   = 16;
   localparam int COORD_W  = 17;
   localparam int COLS_W   = 10;
   localparam int BIAS_W   = 16;
   localparam int GID_W    = 9;
   localparam int PERIOD_W = TIME_W + FRAME_W;
   localparam int PROD_W   = TIME_W + COORD_W;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 80;
   localparam int CSR_AW     = 5;

   localparam logic [1:0] PM_LOOP   = 2'd0;
   localparam logic [1:0] PM_ONCE   = 2'd1;
   localparam logic [1:0] PM_RETURN = 2'd2;
   localparam logic [1:0] PM_BAD    = 2'd3;

   localparam logic [2:0] REG_ENABLE  = 3'd0;
   localparam logic [2:0] REG_COLUMNS = 3'd1;
   localparam logic [2:0] REG_GAIN_L  = 3'd2;
   localparam logic [2:0] REG_GAIN_R  = 3'd3;
   localparam logic [2:0] REG_GAIN_T  = 3'd4;
   localparam logic [2:0] REG_GAIN_B  = 3'd5;
   localparam logic [2:0] REG_BIAS_X  = 3'd6;
   localparam logic [2:0] REG_BIAS_Y  = 3'd7;

   typedef enum logic [3:0] {
      OP_TICK     = 4'd0,
      OP_SET_ANIM = 4'd1,
      OP_SET_FRM  = 4'd2,
      OP_BY_ID    = 4'd3,
      OP_FINISH   = 4'd4,
      OP_RESTART  = 4'd5,
      OP_BEHAVIOR = 4'd6,
      OP_SPEED    = 4'd7,
      OP_WR_FRAME = 4'd8,
      OP_WR_HDR   = 4'd9,
      OP_BAD      = 4'd10
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [TIME_W-1:0]    elapsed;
      logic [ANIM_W-1:0]    anim_sel;
      logic [FRAME_W-1:0]   frame_sel;
      logic [GID_W-1:0]     global_frame;
      logic [1:0]           play_mode;
      logic [SPEED_W-1:0]   speed_value;
      logic [TIME_W-1:0]    hold_value;
      logic [TILE_W-1:0]    tile_value;
      logic [CNT_W-1:0]     count_value;
      logic                 pre_bad;
   } item_type;

   typedef struct packed {
      logic                 enable;
      logic [COLS_W-1:0]    columns;
      logic [COORD_W-1:0]   gain_left;
      logic [COORD_W-1:0]   gain_right;
      logic [COORD_W-1:0]   gain_top;
      logic [COORD_W-1:0]   gain_bottom;
      logic [BIAS_W-1:0]    bias_x;
      logic [BIAS_W-1:0]    bias_y;
   } cfg_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

FILE: hdl/sfs_ram.sv
module sfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/sfs_front.sv
module sfs_front
   import sfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [3:0]            req_tuser,
   input  logic                  q_pop,
   output queue_out_type         q_out
);

   item_type  slot_ff [2];
   item_type  slot_in [2];
   logic      wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   item_type  item_new;
   logic      push, pop, aok, fok;

   // classify
   always_comb begin
      item_new.elapsed      = req_tdata[23:0];
      item_new.anim_sel     = req_tdata[27:24];
      item_new.frame_sel    = req_tdata[32:28];
      item_new.global_frame = req_tdata[41:33];
      item_new.play_mode    = req_tdata[43:42];
      item_new.speed_value  = req_tdata[59:44];
      item_new.hold_value   = req_tdata[83:60];
      item_new.tile_value   = req_tdata[99:84];
      item_new.count_value  = req_tdata[105:100];
      aok = ({1'b0, item_new.anim_sel} < (ANIM_W + 1)'(ANIMATIONS));
      fok = ({1'b0, item_new.frame_sel} < (FRAME_W + 1)'(FRAMES_PER_ANIM));
      item_new.op      = OP_BAD;
      item_new.pre_bad = 1'b1;
      unique case (req_tuser)
         4'd0: begin
            item_new.op = OP_TICK;     item_new.pre_bad = 1'b0;
         end
         4'd1: begin
            item_new.op = OP_SET_ANIM;
            item_new.pre_bad = !aok || (item_new.play_mode == PM_BAD);
         end
         4'd2: begin
            item_new.op = OP_SET_FRM;  item_new.pre_bad = !fok;
         end
         4'd3: begin
            item_new.op = OP_BY_ID;    item_new.pre_bad = 1'b0;
         end
         4'd4: begin
            item_new.op = OP_FINISH;   item_new.pre_bad = 1'b0;
         end
         4'd5: begin
            item_new.op = OP_RESTART;  item_new.pre_bad = 1'b0;
         end
         4'd6: begin
            item_new.op = OP_BEHAVIOR;
            item_new.pre_bad = (item_new.play_mode == PM_BAD);
         end
         4'd7: begin
            item_new.op = OP_SPEED;    item_new.pre_bad = !aok;
         end
         4'd8: begin
            item_new.op = OP_WR_FRAME; item_new.pre_bad = !aok || !fok;
         end
         4'd9: begin
            item_new.op = OP_WR_HDR;
            item_new.pre_bad = !aok || (item_new.count_value == '0)
               || (item_new.count_value > CNT_W'(FRAMES_PER_ANIM))
               || ({1'b0, item_new.frame_sel} >= item_new.count_value);
         end
         default: begin
            item_new.op = OP_BAD;      item_new.pre_bad = 1'b1;
         end
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push = req_tvalid && req_tready;
   assign pop  = q_pop && (count_ff != 2'd0);

   always_comb begin
      slot_in  = slot_ff;
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         slot_in[wptr_ff] = item_new;
         wptr_in = !wptr_ff;
      end
      if (pop) begin
         rptr_in = !rptr_ff;
      end
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = slot_ff[rptr_ff];

endmodule

FILE: hdl/sfs_back.sv
module sfs_back
   import sfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  queue_out_type         q_out,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [17:0] {
      S_IDLE     = 18'h00001,
      S_TICK_MUL = 18'h00002,
      S_TICK_ADD = 18'h00004,
      S_ADV_RD   = 18'h00008,
      S_ADV_CHK  = 18'h00010,
      S_PER_RD   = 18'h00020,
      S_PER_ACC  = 18'h00040,
      S_PER_CHK  = 18'h00080,
      S_ADV_STEP = 18'h00100,
      S_RET_POP  = 18'h00200,
      S_RET_SEL  = 18'h00400,
      S_WALK     = 18'h00800,
      S_CO_RD    = 18'h01000,
      S_CO_TILE  = 18'h02000,
      S_DIV      = 18'h04000,
      S_CO_MUL   = 18'h08000,
      S_CO_ADD   = 18'h10000,
      S_RESP     = 18'h20000
   } state_type;

   localparam int REM_W = PERIOD_W + 1;
   localparam int SUM_W = PROD_W + 2;

   state_type state_ff, state_in, div_ret_ff, div_ret_in, co_ret_ff, co_ret_in;
   item_type  item_ff, item_in;
   logic [ANIM_W-1:0]  anim_ff, anim_in, wa_ff, wa_in;
   logic [1:0]         mode_ff, mode_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [TIME_W-1:0]  timer_ff, timer_in, hold_ff, hold_in;
   logic               done_ff, done_in, bad_ff, bad_in;
   logic [COORD_W-1:0] coord_ff [4];
   logic [COORD_W-1:0] coord_in [4];
   logic [ANIM_W-1:0]  hanim_ff [HISTORY_DEPTH];
   logic [ANIM_W-1:0]  hanim_in [HISTORY_DEPTH];
   logic [1:0]         hmode_ff [HISTORY_DEPTH];
   logic [1:0]         hmode_in [HISTORY_DEPTH];
   logic [HCNT_W-1:0]  hcnt_ff, hcnt_in;
   logic [CNT_W-1:0]   cnt_mem_ff [ANIMATIONS];
   logic [CNT_W-1:0]   cnt_mem_in [ANIMATIONS];
   logic [FRAME_W-1:0] loop_mem_ff [ANIMATIONS];
   logic [FRAME_W-1:0] loop_mem_in [ANIMATIONS];
   logic [SPEED_W-1:0] spd_mem_ff [ANIMATIONS];
   logic [SPEED_W-1:0] spd_mem_in [ANIMATIONS];
   logic [PERIOD_W-1:0] sum_ff, sum_in, divisor_ff, divisor_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [GID_W-1:0]   gf_ff, gf_in;
   logic [1:0]         k_ff, k_in;
   logic [COLS_W-1:0]  col_ff, col_in;
   logic [TILE_W-1:0]  row_ff, row_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [TIME_W-1:0]  quo_ff, quo_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic               div_tile_ff, div_tile_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [ANIM_W-1:0]  cnt_sel;
   logic [CNT_W-1:0]   cnt_raw, c_eff;
   logic [FRAME_W-1:0] ls_now;
   logic [TAB_AW-1:0]  ram_rd_addr;
   logic [39:0]        ram_rd_data;
   logic               ram_wr_en;
   logic [TIME_W-1:0]  ram_hold, h_eff;
   logic [TIME_W-1:0]  mul_a;
   logic [COORD_W-1:0] mul_b;
   logic [REM_W-1:0]   rem_sh;
   logic [TIME_W+4:0]  tick_sum;
   logic [CNT_W:0]     nf;
   logic [COLS_W-1:0]  cols_eff;
   logic signed [SUM_W-1:0] csum, bias_ext;
   logic               push_req;
   logic [ANIM_W-1:0]  push_anim;
   logic [1:0]         push_mode;
   logic [HIDX_W-1:0]  top;
   item_type           qi;

   assign qi       = q_out.item;
   assign cnt_sel  = (state_ff == S_WALK) ? wa_ff : anim_ff;
   assign cnt_raw  = cnt_mem_ff[cnt_sel];
   assign c_eff    = (cnt_raw == '0) ? CNT_W'(1) : cnt_raw;
   assign ls_now   = loop_mem_ff[anim_ff];
   assign ram_hold = ram_rd_data[39:16];
   assign h_eff    = (ram_hold == '0) ? TIME_W'(1) : ram_hold;
   assign cols_eff = (cfg.columns == '0) ? COLS_W'(1) : cfg.columns;
   assign top      = HIDX_W'(hcnt_ff - HCNT_W'(1));
   assign ram_rd_addr = (state_ff == S_PER_RD) ? {anim_ff, idx_ff[FRAME_W-1:0]}
                                                : {anim_ff, frame_ff};
   assign ram_wr_en = (state_ff == S_IDLE) && q_out.valid
                      && (qi.op == OP_WR_FRAME) && !qi.pre_bad;
   assign q_pop     = (state_ff == S_IDLE) && q_out.valid;

   sfs_ram #(.WIDTH(40), .DEPTH(TAB_DEPTH)) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr ({qi.anim_sel, qi.frame_sel}),
      .wr_data ({qi.hold_value, qi.tile_value}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      unique case (k_ff)
         2'd0: begin
            mul_a = TIME_W'(col_ff);                    mul_b = cfg.gain_left;
         end
         2'd1: begin
            mul_a = TIME_W'(col_ff) + TIME_W'(1);       mul_b = cfg.gain_right;
         end
         2'd2: begin
            mul_a = TIME_W'(row_ff);                    mul_b = cfg.gain_top;
         end
         default: begin
            mul_a = TIME_W'(row_ff) + TIME_W'(1);       mul_b = cfg.gain_bottom;
         end
      endcase
      if (state_ff == S_TICK_MUL) begin
         mul_a = item_ff.elapsed;
         mul_b = COORD_W'(spd_mem_ff[anim_ff]);
      end
   end

   always_comb begin
      state_in    = state_ff;
      div_ret_in  = div_ret_ff;
      co_ret_in   = co_ret_ff;
      item_in     = item_ff;
      anim_in     = anim_ff;
      wa_in       = wa_ff;
      mode_in     = mode_ff;
      frame_in    = frame_ff;
      timer_in    = timer_ff;
      hold_in     = hold_ff;
      done_in     = done_ff;
      bad_in      = bad_ff;
      coord_in    = coord_ff;
      hanim_in    = hanim_ff;
      hmode_in    = hmode_ff;
      hcnt_in     = hcnt_ff;
      cnt_mem_in  = cnt_mem_ff;
      loop_mem_in = loop_mem_ff;
      spd_mem_in  = spd_mem_ff;
      sum_in      = sum_ff;
      divisor_in  = divisor_ff;
      idx_in      = idx_ff;
      gf_in       = gf_ff;
      k_in        = k_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      prod_in     = mul_a * mul_b;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dcnt_in     = dcnt_ff;
      div_tile_in = div_tile_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      push_req    = 1'b0;
      push_anim   = anim_ff;
      push_mode   = mode_ff;
      rem_sh      = {rem_ff[REM_W-2:0], quo_ff[TIME_W-1]};
      tick_sum    = (TIME_W + 5)'(timer_ff) + (TIME_W + 5)'(prod_ff[PROD_W-2:12]);
      nf          = (CNT_W + 1)'(frame_ff) + (CNT_W + 1)'(1);
      bias_ext    = k_ff[1] ? SUM_W'($signed(cfg.bias_y)) : SUM_W'($signed(cfg.bias_x));
      csum        = k_ff[0] ? $signed({2'b0, prod_ff}) - bias_ext
                            : $signed({2'b0, prod_ff}) + bias_ext;

      unique case (state_ff)
         S_IDLE: begin
            if (q_out.valid) begin
               item_in   = qi;
               bad_in    = 1'b0;
               co_ret_in = S_RESP;
               state_in  = S_RESP;
               unique case (qi.op)
                  OP_TICK: begin
                     if (cfg.enable) state_in = S_TICK_MUL;
                     else done_in = 1'b1;
                  end
                  OP_SET_ANIM: begin
                     if (qi.pre_bad) begin
                        bad_in = 1'b1;
                     end else if (qi.anim_sel != anim_ff) begin
                        push_req = 1'b1;
                        anim_in  = qi.anim_sel;
                        mode_in  = qi.play_mode;
                        frame_in = '0;
                        done_in  = 1'b0;
                        state_in = S_CO_RD;
                     end
                  end
                  OP_SET_FRM: begin
                     if (qi.pre_bad || ({1'b0, qi.frame_sel} >= c_eff)) begin
                        bad_in = 1'b1;
                     end else begin
                        frame_in = qi.frame_sel;
                        state_in = S_CO_RD;
                     end
                  end
                  OP_BY_ID: begin
                     wa_in    = '0;
                     gf_in    = qi.global_frame;
                     state_in = S_WALK;
                  end
                  OP_FINISH: begin
                     frame_in = FRAME_W'(c_eff - CNT_W'(1));
                     state_in = S_CO_RD;
                  end
                  OP_RESTART: begin
                     frame_in = '0;
                     timer_in = '0;
                     done_in  = 1'b0;
                     state_in = S_CO_RD;
                  end
                  OP_BEHAVIOR: begin
                     if (qi.pre_bad) bad_in = 1'b1;
                     else mode_in = qi.play_mode;
                  end
                  OP_SPEED: begin
                     if (qi.pre_bad) bad_in = 1'b1;
                     else spd_mem_in[qi.anim_sel] = qi.speed_value;
                  end
                  OP_WR_FRAME: begin
                     bad_in = qi.pre_bad;
                  end
                  OP_WR_HDR: begin
                     if (qi.pre_bad) begin
                        bad_in = 1'b1;
                     end else begin
                        cnt_mem_in[qi.anim_sel]  = qi.count_value;
                        loop_mem_in[qi.anim_sel] = qi.frame_sel;
                     end
                  end
                  default: bad_in = 1'b1;
               endcase
            end
         end
         S_TICK_MUL: state_in = S_TICK_ADD;
         S_TICK_ADD: begin
            timer_in = (tick_sum > (TIME_W + 5)'({TIME_W{1'b1}})) ? {TIME_W{1'b1}}
                                                                 : tick_sum[TIME_W-1:0];
            state_in = S_ADV_RD;
         end
         S_ADV_RD: state_in = S_ADV_CHK;
         S_ADV_CHK: begin
            hold_in = h_eff;
            if ((mode_ff == PM_ONCE) && ({1'b0, frame_ff} == c_eff - CNT_W'(1))
                && (timer_ff >= h_eff)) begin
               done_in     = 1'b1;
               divisor_in  = PERIOD_W'(h_eff);
               quo_in      = timer_ff;
               rem_in      = '0;
               dcnt_in     = '0;
               div_tile_in = 1'b0;
               div_ret_in  = S_CO_RD;
               co_ret_in   = S_RESP;
               state_in    = S_DIV;
            end else if ((mode_ff == PM_LOOP) && (frame_ff == ls_now)
                         && ({1'b0, frame_ff} < c_eff)) begin
               sum_in   = '0;
               idx_in   = CNT_W'(frame_ff);
               state_in = S_PER_RD;
            end else begin
               state_in = S_ADV_STEP;
            end
         end
         S_PER_RD: state_in = S_PER_ACC;
         S_PER_ACC: begin
            sum_in = sum_ff + PERIOD_W'(h_eff);
            idx_in = idx_ff + CNT_W'(1);
            state_in = ((idx_ff + CNT_W'(1)) < c_eff) ? S_PER_RD : S_PER_CHK;
         end
         S_PER_CHK: begin
            if (PERIOD_W'(timer_ff) >= sum_ff) begin
               done_in     = 1'b1;
               divisor_in  = sum_ff;
               quo_in      = timer_ff;
               rem_in      = '0;
               dcnt_in     = '0;
               div_tile_in = 1'b0;
               div_ret_in  = S_ADV_STEP;
               state_in    = S_DIV;
            end else begin
               state_in = S_ADV_STEP;
            end
         end
         S_ADV_STEP: begin
            if (timer_ff < hold_ff) begin
               state_in = S_RESP;
            end else begin
               timer_in  = timer_ff - hold_ff;
               co_ret_in = S_ADV_RD;
               state_in  = S_CO_RD;
               frame_in  = FRAME_W'(nf);
               if (nf >= (CNT_W + 1)'(c_eff)) begin
                  done_in = 1'b1;
                  priority if (mode_ff == PM_ONCE) begin
                     frame_in = FRAME_W'(c_eff - CNT_W'(1));
                  end else if (mode_ff == PM_RETURN) begin
                     state_in = S_RET_POP;
                  end else begin
                     frame_in = ({1'b0, ls_now} < c_eff) ? ls_now : '0;
                  end
               end
            end
         end
         S_RET_POP: begin
            priority if ((hcnt_ff != '0) && (hmode_ff[top] == PM_RETURN)) begin
               hcnt_in = hcnt_ff - HCNT_W'(1);
            end else if (hcnt_ff == '0) begin
               hanim_in[0] = '0;
               hmode_in[0] = PM_LOOP;
               hcnt_in     = HCNT_W'(1);
               state_in    = S_RET_SEL;
            end else begin
               state_in = S_RET_SEL;
            end
         end
         S_RET_SEL: begin
            frame_in  = '0;
            co_ret_in = S_ADV_RD;
            state_in  = S_CO_RD;
            if (hanim_ff[top] != anim_ff) begin
               push_req = 1'b1;
               anim_in  = hanim_ff[top];
               mode_in  = hmode_ff[top];
               done_in  = 1'b0;
            end
         end
         S_WALK: begin
            if (gf_ff < GID_W'(c_eff)) begin
               anim_in  = wa_ff;
               frame_in = FRAME_W'(gf_ff);
               state_in = S_CO_RD;
            end else begin
               gf_in = gf_ff - GID_W'(c_eff);
               if (wa_ff == ANIM_W'(ANIMATIONS - 1)) begin
                  bad_in   = 1'b1;
                  state_in = S_RESP;
               end else begin
                  wa_in = wa_ff + ANIM_W'(1);
               end
            end
         end
         S_CO_RD: state_in = S_CO_TILE;
         S_CO_TILE: begin
            quo_in      = TIME_W'(ram_rd_data[TILE_W-1:0]);
            divisor_in  = PERIOD_W'(cols_eff);
            rem_in      = '0;
            dcnt_in     = '0;
            div_tile_in = 1'b1;
            state_in    = S_DIV;
         end
         S_DIV: begin
            if (rem_sh >= REM_W'(divisor_ff)) begin
               rem_in = rem_sh - REM_W'(divisor_ff);
               quo_in = {quo_ff[TIME_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[TIME_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'(TIME_W - 1)) begin
               if (div_tile_ff) begin
                  col_in   = rem_in[COLS_W-1:0];
                  row_in   = quo_in[TILE_W-1:0];
                  k_in     = '0;
                  state_in = S_CO_MUL;
               end else begin
                  timer_in = rem_in[TIME_W-1:0];
                  state_in = div_ret_ff;
               end
            end
         end
         S_CO_MUL: state_in = S_CO_ADD;
         S_CO_ADD: begin
            priority if (csum < 0) begin
               coord_in[k_ff] = '0;
            end else if (csum > SUM_W'({COORD_W{1'b1}})) begin
               coord_in[k_ff] = {COORD_W{1'b1}};
            end else begin
               coord_in[k_ff] = csum[COORD_W-1:0];
            end
            k_in     = k_ff + 2'd1;
            state_in = (k_ff == 2'd3) ? co_ret_ff : S_CO_MUL;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, bad_ff, done_ff, frame_ff, anim_ff,
                               coord_ff[3], coord_ff[2], coord_ff[1], coord_ff[0]};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (push_req) begin
         if (hcnt_ff >= HCNT_W'(HISTORY_DEPTH)) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
               hanim_in[i] = hanim_ff[i+1];
               hmode_in[i] = hmode_ff[i+1];
            end
            hanim_in[HISTORY_DEPTH-1] = push_anim;
            hmode_in[HISTORY_DEPTH-1] = push_mode;
            hcnt_in = HCNT_W'(HISTORY_DEPTH);
         end else begin
            hanim_in[HIDX_W'(hcnt_ff)] = push_anim;
            hmode_in[HIDX_W'(hcnt_ff)] = push_mode;
            hcnt_in = hcnt_ff + HCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      wa_ff       <= wa_in;
      hold_ff     <= hold_in;
      cnt_mem_ff  <= cnt_mem_in;
      loop_mem_ff <= loop_mem_in;
      spd_mem_ff  <= spd_mem_in;
      sum_ff      <= sum_in;
      divisor_ff  <= divisor_in;
      idx_ff      <= idx_in;
      gf_ff       <= gf_in;
      k_ff        <= k_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      div_tile_ff <= div_tile_in;
      div_ret_ff  <= div_ret_in;
      co_ret_ff   <= co_ret_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         anim_ff      <= '0;
         mode_ff      <= PM_LOOP;
         frame_ff     <= '0;
         timer_ff     <= '0;
         done_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         coord_ff     <= '{default: '0};
         hanim_ff     <= '{default: '0};
         hmode_ff     <= '{default: PM_LOOP};
         hcnt_ff      <= HCNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         anim_ff      <= anim_in;
         mode_ff      <= mode_in;
         frame_ff     <= frame_in;
         timer_ff     <= timer_in;
         done_ff      <= done_in;
         bad_ff       <= bad_in;
         coord_ff     <= coord_in;
         hanim_ff     <= hanim_in;
         hmode_ff     <= hmode_in;
         hcnt_ff      <= hcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("back state not one-hot");

   a_hist_bound: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff <= HCNT_W'(HISTORY_DEPTH))
      else $error("history count beyond depth");

   a_resp_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) && (state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("response not loaded");

   a_hist_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RET_SEL) |-> (hcnt_ff != '0))
      else $error("return selected from empty history");

endmodule

FILE: hdl/sprite_frame_sequencer_unit.sv
// Sprite frame sequencer: plays animations out of a sprite sheet and returns one response
// per request with the texture rectangle, animation, frame and status. Table writes,
// behavior, speed and most bad requests go straight from the queue to the response. A
// coordinate update takes a frame RAM read, a 24-step shared restoring divider for the
// tile column and row, then four multiply and clamp passes on one 24x17 multiplier.
// An enabled tick scales elapsed time by the speed, adds it to the timer, then reads and
// checks the current frame; each frame stepped adds a coordinate update, a loop period
// is summed one frame hold at a time and then checked, and a timer remainder uses the
// divider. Frame-by-id walks one animation per cycle (up to 16). A return to the previous
// animation pops one history entry per cycle. A two-entry request queue keeps the input
// open until full while the sequencer works; a response register holds a finished result.
module sprite_frame_sequencer_unit
   import sfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // elapsed, anim_sel, frame_sel, global_frame, play_mode, speed_value, hold_value,
   // tile_value, count_value
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic [3:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // u_left, u_right, v_top, v_bottom, current_anim, current_frame, done_res, bad_request
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg_ff, cfg_in;
   queue_out_type q_out;
   logic          q_pop, csr_wr;
   logic [2:0]    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_ENABLE:  cfg_in.enable      = csr_pwdata[0];
            REG_COLUMNS: cfg_in.columns     = csr_pwdata[COLS_W-1:0];
            REG_GAIN_L:  cfg_in.gain_left   = csr_pwdata[COORD_W-1:0];
            REG_GAIN_R:  cfg_in.gain_right  = csr_pwdata[COORD_W-1:0];
            REG_GAIN_T:  cfg_in.gain_top    = csr_pwdata[COORD_W-1:0];
            REG_GAIN_B:  cfg_in.gain_bottom = csr_pwdata[COORD_W-1:0];
            REG_BIAS_X:  cfg_in.bias_x      = csr_pwdata[BIAS_W-1:0];
            REG_BIAS_Y:  cfg_in.bias_y      = csr_pwdata[BIAS_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ENABLE:  csr_prdata = 32'(cfg_ff.enable);
         REG_COLUMNS: csr_prdata = 32'(cfg_ff.columns);
         REG_GAIN_L:  csr_prdata = 32'(cfg_ff.gain_left);
         REG_GAIN_R:  csr_prdata = 32'(cfg_ff.gain_right);
         REG_GAIN_T:  csr_prdata = 32'(cfg_ff.gain_top);
         REG_GAIN_B:  csr_prdata = 32'(cfg_ff.gain_bottom);
         REG_BIAS_X:  csr_prdata = 32'(cfg_ff.bias_x);
         REG_BIAS_Y:  csr_prdata = 32'(cfg_ff.bias_y);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable      <= 1'b0;
         cfg_ff.columns     <= COLS_W'(1);
         cfg_ff.gain_left   <= COORD_W'(65536);
         cfg_ff.gain_right  <= COORD_W'(65536);
         cfg_ff.gain_top    <= COORD_W'(65536);
         cfg_ff.gain_bottom <= COORD_W'(65536);
         cfg_ff.bias_x      <= '0;
         cfg_ff.bias_y      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_pop      (q_pop),
      .q_out      (q_out)
   );

   sfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
